// File: hw/rtl/c3mt_pkg.sv
// ----------------------------------------------------------------------------
// c3mt_pkg
// Shared widths, codes and types of the multichannel 3x3 convolution tile.
// ----------------------------------------------------------------------------
package c3mt_pkg;

  localparam int DATA_W    = 32;
  localparam int IDX_W     = 5;
  localparam int ROW_OUT_W = 2;
  localparam int COL_OUT_W = 8;
  localparam int APB_AW    = 3;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  localparam logic REG_BIAS = 1'b0;

  typedef enum logic {
    OP_WEIGHT = 1'b0,
    OP_PIXEL  = 1'b1
  } c3mt_op_e;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] out_row;
    logic [COL_OUT_W-1:0] out_col;
    logic                 tile_last;
  } c3mt_tag_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sum;
    c3mt_tag_t                tag;
  } c3mt_result_t;

endpackage

// File: hw/rtl/c3mt_in_if.sv
// ----------------------------------------------------------------------------
// c3mt_in_if
// Input channel: weight writes and pixel pushes with valid/ready.
// ----------------------------------------------------------------------------
interface c3mt_in_if;

  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [c3mt_pkg::IDX_W-1:0]          weight_index;
  logic signed [c3mt_pkg::DATA_W-1:0]  weight_value;
  logic signed [c3mt_pkg::DATA_W-1:0]  pixel_ch0;
  logic signed [c3mt_pkg::DATA_W-1:0]  pixel_ch1;
  logic signed [c3mt_pkg::DATA_W-1:0]  pixel_ch2;

  modport source (
    output valid, operation, weight_index, weight_value, pixel_ch0, pixel_ch1, pixel_ch2,
    input  ready
  );

  modport sink (
    input  valid, operation, weight_index, weight_value, pixel_ch0, pixel_ch1, pixel_ch2,
    output ready
  );

endinterface

// File: hw/rtl/c3mt_out_if.sv
// ----------------------------------------------------------------------------
// c3mt_out_if
// Result channel: convolution sums with their tile position, valid/ready.
// ----------------------------------------------------------------------------
interface c3mt_out_if;

  logic                                  valid;
  logic                                  ready;
  logic signed [c3mt_pkg::DATA_W-1:0]    sum;
  logic [c3mt_pkg::ROW_OUT_W-1:0]        out_row;
  logic [c3mt_pkg::COL_OUT_W-1:0]        out_col;
  logic                                  tile_last;

  modport source (
    output valid, sum, out_row, out_col, tile_last,
    input  ready
  );

  modport sink (
    input  valid, sum, out_row, out_col, tile_last,
    output ready
  );

endinterface

// File: hw/rtl/c3mt_dot.sv
// ----------------------------------------------------------------------------
// c3mt_dot
// Pipelined dot product: parallel multiplier lanes, registered adder tree
// with the bias as one extra leaf, and saturation to signed 32 bits.
// ----------------------------------------------------------------------------
module c3mt_dot #(
  parameter int NW = 27
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic signed [c3mt_pkg::DATA_W-1:0]  win_i [NW],
  input  logic signed [c3mt_pkg::DATA_W-1:0]  weight_i [NW],
  input  logic signed [c3mt_pkg::DATA_W-1:0]  bias_i,
  input  c3mt_pkg::c3mt_tag_t                 tag_i,
  output logic                                out_valid_o,
  output c3mt_pkg::c3mt_result_t              out_o
);

  localparam int NTERMS = NW + 1;
  localparam int LEVELS = $clog2(NTERMS);
  localparam int PROD_W = 2 * c3mt_pkg::DATA_W;
  localparam int ACC_W  = PROD_W + LEVELS;
  localparam int HI_W   = ACC_W - c3mt_pkg::DATA_W + 1;

  function automatic int lvl_cnt(int l);
    return (NTERMS + (1 << l) - 1) >> l;
  endfunction

  function automatic int lvl_off(int l);
    int acc;
    acc = 0;
    for (int j = 0; j < l; j++) begin
      acc += lvl_cnt(j);
    end
    return acc;
  endfunction

  localparam int TOTAL = lvl_off(LEVELS + 1);
  localparam int ROOT  = lvl_off(LEVELS);

  logic signed [PROD_W-1:0] prod [NW];
  logic signed [ACC_W-1:0]  node_q [TOTAL];
  logic                     vld_q [LEVELS+1];
  c3mt_pkg::c3mt_tag_t      tag_q [LEVELS+1];
  logic [HI_W-1:0]          root_hi;
  logic signed [c3mt_pkg::DATA_W-1:0] sat;
  logic                     out_valid_q;
  c3mt_pkg::c3mt_result_t   out_q;

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      prod[i] = win_i[i] * weight_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NW; i++) begin
      node_q[i] <= ACC_W'(prod[i]);
    end
    node_q[NW] <= ACC_W'(bias_i);
    for (int l = 1; l <= LEVELS; l++) begin
      for (int i = 0; i < NTERMS; i++) begin
        if (i < lvl_cnt(l)) begin
          if (2 * i + 1 < lvl_cnt(l - 1)) begin
            node_q[lvl_off(l) + i] <= node_q[lvl_off(l - 1) + 2 * i]
                                    + node_q[lvl_off(l - 1) + 2 * i + 1];
          end else begin
            node_q[lvl_off(l) + i] <= node_q[lvl_off(l - 1) + 2 * i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l <= LEVELS; l++) begin
        vld_q[l] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else begin
      vld_q[0] <= in_valid_i;
      for (int l = 1; l <= LEVELS; l++) begin
        vld_q[l] <= vld_q[l-1];
      end
      out_valid_q <= vld_q[LEVELS];
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0] <= tag_i;
    for (int l = 1; l <= LEVELS; l++) begin
      tag_q[l] <= tag_q[l-1];
    end
    out_q.sum <= sat;
    out_q.tag <= tag_q[LEVELS];
  end

  always_comb begin
    root_hi = node_q[ROOT][ACC_W-1:c3mt_pkg::DATA_W-1];
    if ((&root_hi) || !(|root_hi)) begin
      sat = node_q[ROOT][c3mt_pkg::DATA_W-1:0];
    end else if (node_q[ROOT][ACC_W-1]) begin
      sat = c3mt_pkg::SAT_MIN;
    end else begin
      sat = c3mt_pkg::SAT_MAX;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: hw/rtl/c3mt_fifo.sv
// ----------------------------------------------------------------------------
// c3mt_fifo
// Result queue between the dot-product pipeline and the output channel.
// The producer reserves space before it starts, so a push never finds it full.
// ----------------------------------------------------------------------------
module c3mt_fifo #(
  parameter int DEPTH = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  c3mt_pkg::c3mt_result_t data_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output c3mt_pkg::c3mt_result_t data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  c3mt_pkg::c3mt_result_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CNT_W'(push_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/conv3x3_multichannel_tile.sv
// ----------------------------------------------------------------------------
// conv3x3_multichannel_tile
// Stride-1 unpadded KxK convolution over a tile of multichannel pixel rows,
// one output channel, with bias and saturation to signed 32 bits.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock, weight write or pixel push, and
// keeps that rate as long as results are drained: each pixel costs one read
// and one write of the line memory (IN_WIDTH entries, one per column, holding
// the KERNEL_SIZE-1 earlier rows) and one pass through the parallel multiplier
// lanes. Results pass the input stage, the dot product's leaf, tree and output
// registers and the result queue. Up to $clog2(KERNEL_SIZE*KERNEL_SIZE*CHANNELS
// +1)+5 results may be pending; with that many undelivered, input ready
// drops until the output side takes one. Weights take effect for every pixel
// accepted after the write. The line memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module conv3x3_multichannel_tile #(
  parameter int IN_WIDTH    = 224,
  parameter int KERNEL_SIZE = 3,
  parameter int CHANNELS    = 3,
  parameter int OUT_ROWS    = 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  c3mt_in_if.sink                            item_i,
  c3mt_out_if.source                         result_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [c3mt_pkg::APB_AW-1:0]        paddr,
  input  logic [c3mt_pkg::DATA_W-1:0]        pwdata,
  output logic [c3mt_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int DW         = c3mt_pkg::DATA_W;
  localparam int K          = KERNEL_SIZE;
  localparam int C          = CHANNELS;
  localparam int NW         = K * K * C;
  localparam int TILE_ROWS  = OUT_ROWS + K - 1;
  localparam int COL_W      = $clog2(IN_WIDTH);
  localparam int ROW_W      = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int LB_ROWS    = (K > 1) ? K - 1 : 1;
  localparam int LB_W       = LB_ROWS * C * DW;
  localparam int LEVELS     = $clog2(NW + 1);
  localparam int FIFO_DEPTH = LEVELS + 5;
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(IN_WIDTH - 1);
  localparam logic [COL_W-1:0] COL_KM1  = COL_W'(K - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(TILE_ROWS - 1);
  localparam logic [ROW_W-1:0] ROW_KM1  = ROW_W'(K - 1);
  localparam logic [OCC_W-1:0] OCC_MAX  = OCC_W'(FIFO_DEPTH);

  logic                       in_acc;
  logic                       pix_acc;
  logic                       w_acc;
  logic                       out_acc;
  logic                       emit;
  logic [ROW_W-1:0]           orow;
  logic [COL_W-1:0]           ocol;
  c3mt_pkg::c3mt_tag_t        tag_d;

  logic [COL_W-1:0]           col_q, col_d;
  logic [ROW_W-1:0]           row_q, row_d;
  logic [OCC_W-1:0]           occ_q, occ_d;
  logic signed [DW-1:0]       bias_q;
  logic signed [DW-1:0]       w_q [NW];

  logic                       s1_valid_q;
  logic                       s1_emit_q;
  logic [COL_W-1:0]           s1_col_q;
  c3mt_pkg::c3mt_tag_t        s1_tag_q;
  logic signed [DW-1:0]       s1_px_q [C];

  logic [LB_W-1:0]            lb_mem [IN_WIDTH];
  logic [LB_W-1:0]            lb_rd_q;
  logic [LB_W-1:0]            lb_wr;
  logic signed [DW-1:0]       px [C];
  logic signed [DW-1:0]       column [K][C];
  logic signed [DW-1:0]       win_q [NW];
  logic signed [DW-1:0]       win_d [NW];

  logic                       dot_valid;
  logic                       dot_res_valid;
  c3mt_pkg::c3mt_result_t     dot_res;
  c3mt_pkg::c3mt_result_t     fifo_res;

  assign item_i.ready = (occ_q < OCC_MAX);
  assign in_acc       = item_i.valid && item_i.ready;
  assign pix_acc      = in_acc && (item_i.operation == c3mt_pkg::OP_PIXEL);
  assign w_acc        = in_acc && (item_i.operation == c3mt_pkg::OP_WEIGHT);
  assign out_acc      = result_o.valid && result_o.ready;

  assign emit = (row_q >= ROW_KM1) && (col_q >= COL_KM1);
  assign orow = row_q - ROW_KM1;
  assign ocol = col_q - COL_KM1;

  always_comb begin
    tag_d.out_row   = c3mt_pkg::ROW_OUT_W'(orow);
    tag_d.out_col   = c3mt_pkg::COL_OUT_W'(ocol);
    tag_d.tile_last = (row_q == ROW_LAST) && (col_q == COL_LAST);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (pix_acc) begin
      if (col_q == COL_LAST) begin
        col_d = '0;
        row_d = (row_q == ROW_LAST) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
    occ_d = occ_q + OCC_W'(pix_acc && emit) - OCC_W'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      occ_q      <= '0;
      s1_valid_q <= 1'b0;
      bias_q     <= '0;
      for (int i = 0; i < NW; i++) begin
        w_q[i]   <= '0;
        win_q[i] <= '0;
      end
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      occ_q      <= occ_d;
      s1_valid_q <= pix_acc;
      if (psel && penable && pwrite && (paddr[2] == c3mt_pkg::REG_BIAS)) begin
        bias_q <= pwdata;
      end
      for (int i = 0; i < NW; i++) begin
        if (w_acc && (i < (1 << c3mt_pkg::IDX_W)) &&
            (item_i.weight_index == c3mt_pkg::IDX_W'(i))) begin
          w_q[i] <= item_i.weight_value;
        end
      end
      if (s1_valid_q) begin
        for (int i = 0; i < NW; i++) begin
          win_q[i] <= win_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_emit_q <= emit;
      s1_col_q  <= col_q;
      s1_tag_q  <= tag_d;
      for (int ch = 0; ch < C; ch++) begin
        if (ch == 0) begin
          s1_px_q[ch] <= item_i.pixel_ch0;
        end else if (ch == 1) begin
          s1_px_q[ch] <= item_i.pixel_ch1;
        end else if (ch == 2) begin
          s1_px_q[ch] <= item_i.pixel_ch2;
        end else begin
          s1_px_q[ch] <= '0;
        end
      end
    end
  end

  // line memory: read at accept, write back in the cycle after
  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      lb_rd_q <= lb_mem[col_q];
    end
    if (s1_valid_q) begin
      lb_mem[s1_col_q] <= lb_wr;
    end
  end

  always_comb begin
    for (int ch = 0; ch < C; ch++) begin
      px[ch] = s1_px_q[ch];
    end
    for (int r = 0; r < K; r++) begin
      for (int ch = 0; ch < C; ch++) begin
        if (r < K - 1) begin
          column[r][ch] = lb_rd_q[(r * C + ch) * DW +: DW];
        end else begin
          column[r][ch] = px[ch];
        end
      end
    end
    lb_wr = '0;
    for (int r = 0; r < LB_ROWS; r++) begin
      for (int ch = 0; ch < C; ch++) begin
        if (r + 1 < K) begin
          lb_wr[(r * C + ch) * DW +: DW] = column[r + 1][ch];
        end
      end
    end
    for (int r = 0; r < K; r++) begin
      for (int c = 0; c < K; c++) begin
        for (int ch = 0; ch < C; ch++) begin
          if (c < K - 1) begin
            win_d[(r * K + c) * C + ch] = win_q[(r * K + c + 1) * C + ch];
          end else begin
            win_d[(r * K + c) * C + ch] = column[r][ch];
          end
        end
      end
    end
  end

  assign dot_valid = s1_valid_q && s1_emit_q;

  c3mt_dot #(
    .NW (NW)
  ) u_c3mt_dot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dot_valid),
    .win_i       (win_d),
    .weight_i    (w_q),
    .bias_i      (bias_q),
    .tag_i       (s1_tag_q),
    .out_valid_o (dot_res_valid),
    .out_o       (dot_res)
  );

  c3mt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_c3mt_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (dot_res_valid),
    .data_i  (dot_res),
    .valid_o (result_o.valid),
    .ready_i (result_o.ready),
    .data_o  (fifo_res)
  );

  assign result_o.sum       = fifo_res.sum;
  assign result_o.out_row   = fifo_res.tag.out_row;
  assign result_o.out_col   = fifo_res.tag.out_col;
  assign result_o.tile_last = fifo_res.tag.tile_last;

  assign prdata = (paddr[2] == c3mt_pkg::REG_BIAS) ? bias_q : '0;
  assign pready = 1'b1;

endmodule

// File: hw/rtl/c3mt_checker.sv
// ----------------------------------------------------------------------------
// c3mt_checker
// Port-level checks of the convolution tile, bound to the top level.
// ----------------------------------------------------------------------------
module c3mt_checker #(
  parameter int IN_WIDTH    = 224,
  parameter int KERNEL_SIZE = 3,
  parameter int OUT_ROWS    = 3
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [c3mt_pkg::DATA_W-1:0]  out_sum_i,
  input logic [c3mt_pkg::ROW_OUT_W-1:0]      out_row_i,
  input logic [c3mt_pkg::COL_OUT_W-1:0]      out_col_i,
  input logic                                out_last_i,
  input logic                                psel_i,
  input logic                                penable_i,
  input logic                                pwrite_i,
  input logic [c3mt_pkg::APB_AW-1:0]         paddr_i,
  input logic [c3mt_pkg::DATA_W-1:0]         pwdata_i,
  input logic [c3mt_pkg::DATA_W-1:0]         prdata_i,
  input logic                                pready_i
);

  localparam logic [c3mt_pkg::ROW_OUT_W-1:0] LAST_ROW = c3mt_pkg::ROW_OUT_W'(OUT_ROWS - 1);
  localparam logic [c3mt_pkg::COL_OUT_W-1:0] LAST_COL =
    c3mt_pkg::COL_OUT_W'(IN_WIDTH - KERNEL_SIZE);

  a_tile_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_last_i) |-> (out_row_i == LAST_ROW) && (out_col_i == LAST_COL))
    else $error("tile_last away from the final output position");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(out_sum_i) &&
                                      $stable(out_col_i) && $stable(out_row_i))
    else $error("stalled result transaction changed");

  a_bias_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel_i && penable_i && pwrite_i && pready_i && (paddr_i[2] == c3mt_pkg::REG_BIAS))
    |=> (paddr_i[2] != c3mt_pkg::REG_BIAS) || (prdata_i == $past(pwdata_i)))
    else $error("bias register does not read back the written value");

endmodule

bind conv3x3_multichannel_tile c3mt_checker #(
  .IN_WIDTH    (IN_WIDTH),
  .KERNEL_SIZE (KERNEL_SIZE),
  .OUT_ROWS    (OUT_ROWS)
) u_c3mt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_sum_i   (result_o.sum),
  .out_row_i   (result_o.out_row),
  .out_col_i   (result_o.out_col),
  .out_last_i  (result_o.tile_last),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata),
  .pready_i    (pready)
);

// File: tb/sv/conv3x3_multichannel_tile_tb.sv
// ----------------------------------------------------------------------------
// conv3x3_multichannel_tile_tb
// Self-checking bench for the 3x3 three-channel convolution tile. A directed
// table opens the run: warm-up pixels, zero weights, the extreme weights,
// ignored weight slots and both saturation limits. Five phases follow. Each
// one sets the bias over APB and reloads the weights, then streams random
// weight writes and raster pixels. A bit-accurate model of the window and
// its wide accumulator predicts every result. The phases vary value
// magnitude, bias extremes, sender gaps and result back-pressure.
// ----------------------------------------------------------------------------
module conv3x3_multichannel_tile_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import c3mt_pkg::*;

  localparam int IN_W            = 224;
  localparam int K               = 3;
  localparam int CH              = 3;
  localparam int OROWS           = 3;
  localparam int NUM_W           = K * K * CH;
  localparam int OUT_W           = IN_W - K + 1;
  localparam int TILE_ROWS       = OROWS + K - 1;
  localparam int DRAIN_CYCLES    = 16;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int NUM_PHASES      = 5;
  localparam int NUM_DIRECTED    = 13;

  localparam logic [APB_AW-1:0] BIAS_ADDR = APB_AW'(4 * int'(REG_BIAS));

  typedef enum {MAG_SMALL, MAG_MEDIUM, MAG_FULL, MAG_MIXED} mag_e;

  typedef struct packed {
    c3mt_op_e                 op;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] wval;
    logic signed [DATA_W-1:0] px0;
    logic signed [DATA_W-1:0] px1;
    logic signed [DATA_W-1:0] px2;
    int unsigned              reps;
    logic                     has_sum;
    logic signed [DATA_W-1:0] known_sum;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  c3mt_in_if  item_if ();
  c3mt_out_if result_if ();

  conv3x3_multichannel_tile DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk_i = ~clk_i;

  // Tile model state
  logic signed [DATA_W-1:0] weights  [NUM_W];
  logic signed [DATA_W-1:0] line_buf [K-1][IN_W][CH];
  logic signed [DATA_W-1:0] window   [K][K][CH];
  logic signed [DATA_W-1:0] bias_reg;
  int unsigned              col_cnt;
  int unsigned              row_cnt;

  c3mt_result_t expected_sums [$];
  int unsigned  errors;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;

  stim_t directed [NUM_DIRECTED] = '{
    '{OP_PIXEL,  5'd0,  32'sd0,  SAT_MAX, SAT_MIN, 32'sd0,  1,   1'b0, 32'sd0},
    '{OP_PIXEL,  5'd0,  32'sd0,  32'sd1,  32'sd2,  32'sd3,  449, 1'b0, 32'sd0},
    '{OP_PIXEL,  5'd0,  32'sd0,  SAT_MIN, SAT_MIN, SAT_MIN, 2,   1'b1, 32'sd0},
    '{OP_WEIGHT, 5'd0,  SAT_MAX, 32'sd0,  32'sd0,  32'sd0,  1,   1'b0, 32'sd0},
    '{OP_WEIGHT, 5'd13, -32'sd1, 32'sd0,  32'sd0,  32'sd0,  1,   1'b0, 32'sd0},
    '{OP_WEIGHT, 5'd26, SAT_MIN, 32'sd0,  32'sd0,  32'sd0,  1,   1'b0, 32'sd0},
    '{OP_WEIGHT, 5'd27, 32'sd7,  32'sd0,  32'sd0,  32'sd0,  1,   1'b0, 32'sd0},
    '{OP_WEIGHT, 5'd31, SAT_MAX, 32'sd0,  32'sd0,  32'sd0,  1,   1'b0, 32'sd0},
    '{OP_PIXEL,  5'd0,  32'sd0,  SAT_MAX, SAT_MAX, SAT_MAX, 3,   1'b1, SAT_MIN},
    '{OP_PIXEL,  5'd0,  32'sd0,  SAT_MIN, SAT_MIN, SAT_MIN, 3,   1'b1, SAT_MAX},
    '{OP_PIXEL,  5'd0,  32'sd0,  -32'sd1, -32'sd1, -32'sd1, 1,   1'b1, SAT_MAX},
    '{OP_PIXEL,  5'd0,  32'sd0,  32'sd0,  32'sd0,  32'sd0,  1,   1'b1, 32'sh7FFF_FFFD},
    '{OP_PIXEL,  5'd0,  32'sd0,  32'sd0,  32'sd0,  32'sd1,  1,   1'b1, -32'sd3}
  };

  function automatic void check_field(string name, logic signed [DATA_W-1:0] exp_v,
                                      logic signed [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_word(mag_e mag);
    int unsigned sel;
    sel = $urandom_range(99);
    if (mag == MAG_MIXED) begin
      mag = mag_e'($urandom_range(2));
    end
    if (mag == MAG_FULL && sel < 12) begin
      case (sel % 4)
        0: begin
          return SAT_MAX;
        end
        1: begin
          return SAT_MIN;
        end
        2: begin
          return '0;
        end
        default: begin
          return '1;
        end
      endcase
    end
    case (mag)
      MAG_SMALL: begin
        return int'($urandom_range(511)) - 256;
      end
      MAG_MEDIUM: begin
        return int'($urandom_range(65535)) - 32768;
      end
      default: begin
        return $urandom();
      end
    endcase
  endfunction

  function automatic stim_t random_item(mag_e mag);
    stim_t s;
    s.op        = ($urandom_range(99) < 10) ? OP_WEIGHT : OP_PIXEL;
    s.idx       = IDX_W'($urandom_range(31));
    s.wval      = pick_word(mag);
    s.px0       = pick_word(mag);
    s.px1       = pick_word(mag);
    s.px2       = pick_word(mag);
    s.reps      = 1;
    s.has_sum   = 1'b0;
    s.known_sum = '0;
    return s;
  endfunction

  // Advance the tile model by one transaction; returns 1 when a sum is due.
  function automatic bit conv_step(input stim_t s, output c3mt_result_t res);
    logic signed [DATA_W-1:0] column [K][CH];
    logic signed [DATA_W-1:0] px [CH];
    logic signed [127:0]      acc;
    int unsigned              col;
    bit                       produced;
    res      = '0;
    produced = 1'b0;
    if (s.op == OP_WEIGHT) begin
      if (s.idx < NUM_W) begin
        weights[s.idx] = s.wval;
      end
      return 1'b0;
    end
    px[0] = s.px0;
    px[1] = s.px1;
    px[2] = s.px2;
    col = (col_cnt >= IN_W) ? 0 : col_cnt;
    for (int ch = 0; ch < CH; ch++) begin
      for (int r = 0; r < K - 1; r++) begin
        column[r][ch] = line_buf[r][col][ch];
      end
      column[K-1][ch] = px[ch];
      for (int r = 0; r < K - 1; r++) begin
        line_buf[r][col][ch] = column[r+1][ch];
      end
    end
    for (int r = 0; r < K; r++) begin
      for (int c = 0; c < K - 1; c++) begin
        for (int ch = 0; ch < CH; ch++) begin
          window[r][c][ch] = window[r][c+1][ch];
        end
      end
      for (int ch = 0; ch < CH; ch++) begin
        window[r][K-1][ch] = column[r][ch];
      end
    end
    if (row_cnt >= K - 1 && col >= K - 1) begin
      acc = 128'(bias_reg);
      for (int r = 0; r < K; r++) begin
        for (int c = 0; c < K; c++) begin
          for (int ch = 0; ch < CH; ch++) begin
            acc += window[r][c][ch] * weights[(r * K + c) * CH + ch];
          end
        end
      end
      if (acc > SAT_MAX) begin
        res.sum = SAT_MAX;
      end else if (acc < SAT_MIN) begin
        res.sum = SAT_MIN;
      end else begin
        res.sum = acc[DATA_W-1:0];
      end
      res.tag.out_row   = ROW_OUT_W'(row_cnt - (K - 1));
      res.tag.out_col   = COL_OUT_W'(col - (K - 1));
      res.tag.tile_last = (row_cnt - (K - 1) == OROWS - 1) && (col - (K - 1) == OUT_W - 1);
      produced = 1'b1;
    end
    if (col + 1 >= IN_W) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= TILE_ROWS) ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col + 1;
    end
    return produced;
  endfunction

  task automatic send_transaction(input stim_t s);
    c3mt_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid        <= 1'b1;
    item_if.operation    <= s.op;
    item_if.weight_index <= s.idx;
    item_if.weight_value <= s.wval;
    item_if.pixel_ch0    <= s.px0;
    item_if.pixel_ch1    <= s.px1;
    item_if.pixel_ch2    <= s.px2;
    do @(posedge clk_i); while (!item_if.ready);
    if (conv_step(s, res)) begin
      if (s.has_sum) begin
        res.sum = s.known_sum;
      end
      expected_sums.push_back(res);
    end
  endtask

  task automatic hold_until_drained();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_sums.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_bias_readback();
    logic [DATA_W-1:0] rd;
    apb_access(1'b0, BIAS_ADDR, '0, rd);
    check_field("bias_value", bias_reg, rd);
  endtask

  always @(posedge clk_i) begin
    c3mt_result_t exp_r;
    if (result_if.valid && result_if.ready) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected result: sum %0d, out_row %0d, out_col %0d",
               result_if.sum, result_if.out_row, result_if.out_col);
        errors++;
      end else begin
        exp_r = expected_sums.pop_front();
        check_field("sum", exp_r.sum, result_if.sum);
        check_field("out_row", exp_r.tag.out_row, result_if.out_row);
        check_field("out_col", exp_r.tag.out_col, result_if.out_col);
        check_field("tile_last", exp_r.tag.tile_last, result_if.tile_last);
      end
    end
    result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    stim_t                    s;
    logic [DATA_W-1:0]        rd;
    logic signed [DATA_W-1:0] bias_val;
    mag_e                     mag;
    errors         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    bias_reg       = '0;
    col_cnt        = 0;
    row_cnt        = 0;
    foreach (weights[i]) weights[i] = '0;
    foreach (line_buf[r, c, ch]) line_buf[r][c][ch] = '0;
    foreach (window[r, c, ch]) window[r][c][ch] = '0;

    rst_ni               = 1'b0;
    item_if.valid        = 1'b0;
    item_if.operation    = OP_WEIGHT;
    item_if.weight_index = '0;
    item_if.weight_value = '0;
    item_if.pixel_ch0    = '0;
    item_if.pixel_ch1    = '0;
    item_if.pixel_ch2    = '0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_bias_readback();
    foreach (directed[i]) begin
      repeat (directed[i].reps) send_transaction(directed[i]);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          bias_val = SAT_MAX; mag = MAG_SMALL;  send_idle_pct = 0;  recv_stall_pct = 0;
        end
        1: begin
          bias_val = SAT_MIN; mag = MAG_SMALL;  send_idle_pct = 47; recv_stall_pct = 0;
        end
        2: begin
          bias_val = $urandom(); mag = MAG_MEDIUM; send_idle_pct = 0; recv_stall_pct = 47;
        end
        3: begin
          bias_val = $urandom(); mag = MAG_FULL; send_idle_pct = 19; recv_stall_pct = 19;
        end
        default: begin
          bias_val = '0; mag = MAG_MIXED; send_idle_pct = 0; recv_stall_pct = 0;
        end
      endcase
      hold_until_drained();
      apb_access(1'b1, BIAS_ADDR, bias_val, rd);
      bias_reg = bias_val;
      check_bias_readback();
      for (int i = 0; i < NUM_W; i++) begin
        s     = random_item(mag);
        s.op  = OP_WEIGHT;
        s.idx = IDX_W'(i);
        send_transaction(s);
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == NUM_PHASES - 1 && i == ITEMS_PER_PHASE / 2) begin
          hold_until_drained();
        end
        send_transaction(random_item(mag));
      end
    end

    hold_until_drained();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
